FILE: rtl/uer_pkg.sv
// Shared types and constants for the echo-pulse ranger.
// Used by uer_ctrl, uer_dp and the top level ultrasonic_echo_ranger.
package uer_pkg;

    // Echo width counter size and derived widths
    localparam int ECHO_COUNT_BITS = 16;
    localparam int DIV_CNT_W       = $clog2(ECHO_COUNT_BITS + 1);
    localparam int TICK_W          = 20;
    localparam int DIST_W          = 16;
    localparam int CFG_DATA_W      = 20;

    // Reset values of the configuration registers
    localparam logic [7:0]        TRIGGER_TICKS_RST = 8'd20;
    localparam logic [TICK_W-1:0] STARTUP_TICKS_RST = 20'd30000;
    localparam logic [TICK_W-1:0] POLL_TICKS_RST    = 20'd500000;
    localparam logic [7:0]        DIVISOR_RST       = 8'd58;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_STARTUP_TICKS = 2'd1,
        REG_POLL_TICKS    = 2'd2,
        REG_DIVISOR       = 2'd3
    } cfg_idx_t;

    // Measurement phase
    typedef enum logic [2:0] {
        PH_STARTUP,
        PH_TRIGGER,
        PH_WAIT,
        PH_MEASURE,
        PH_POLL
    } phase_t;

    // Controller sequencing state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        TICK_HOLD,
        TICK_CLEAR,
        TICK_INC,
        TICK_ONE
    } tick_op_t;

    typedef enum logic [1:0] {
        WIDTH_HOLD,
        WIDTH_ONE,
        WIDTH_INC
    } width_op_t;

    // Configuration values as seen by the datapath
    typedef struct packed {
        logic [7:0]        trigger_ticks;
        logic [TICK_W-1:0] startup_ticks;
        logic [TICK_W-1:0] poll_ticks;
        logic [7:0]        divisor;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      latch_echo;
        tick_op_t  tick_op;
        width_op_t width_op;
        logic      div_start;
        logic      dist_load;
        logic      base_set;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic echo;
        logic startup_done;
        logic trig_first_done;
        logic trig_done;
        logic poll_done;
        logic div_done;
        logic baseline_taken;
        logic dist_differs;
    } sts_t;

endpackage

FILE: rtl/uer_dp.sv
// Datapath of the echo-pulse ranger: tick counter, echo width counter,
// restoring divider, stored distance. Depends on uer_pkg.
module uer_dp
    import uer_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              echo_level,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic [DIST_W-1:0] last_distance
);

    localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = {ECHO_COUNT_BITS{1'b1}};

    logic                       echo_reg;
    logic [TICK_W-1:0]          tick_reg, tick_next;
    logic [ECHO_COUNT_BITS-1:0] width_reg, width_next;
    logic [DIST_W-1:0]          dist_reg;
    logic                       base_reg;

    logic                       div_busy_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic [ECHO_COUNT_BITS-1:0] quo_reg;
    logic [7:0]                 rem_reg;

    logic [8:0]                 shifted;
    logic                       q_bit;
    logic [8:0]                 rem_sub;
    logic [31:0]                quo_ext;
    logic [DIST_W-1:0]          dist_new;
    logic [TICK_W:0]            tick_plus1;

    // Echo sample of the accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            echo_reg <= 1'b0;
        else if (cmd.latch_echo)
            echo_reg <= echo_level;
    end

    // Tick and echo width counters
    always_comb
    begin
        case (cmd.tick_op)
            TICK_CLEAR: tick_next = '0;
            TICK_INC:   tick_next = tick_reg + 1'b1;
            TICK_ONE:   tick_next = TICK_W'(1);
            default:    tick_next = tick_reg;
        endcase
        case (cmd.width_op)
            WIDTH_ONE:  width_next = ECHO_COUNT_BITS'(1);
            WIDTH_INC:  width_next = (width_reg == ECHO_MAX) ? width_reg : width_reg + 1'b1;
            default:    width_next = width_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            width_reg <= '0;
            dist_reg  <= '0;
            base_reg  <= 1'b0;
        end
        else
        begin
            tick_reg  <= tick_next;
            width_reg <= width_next;
            if (cmd.dist_load)
                dist_reg <= dist_new;
            if (cmd.base_set)
                base_reg <= 1'b1;
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[ECHO_COUNT_BITS-1]};
    assign q_bit   = (shifted >= {1'b0, cfg.divisor});
    assign rem_sub = shifted - {1'b0, cfg.divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= DIV_CNT_W'(ECHO_COUNT_BITS);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(1))
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= width_reg;
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            quo_reg <= {quo_reg[ECHO_COUNT_BITS-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[7:0] : shifted[7:0];
        end
    end

    // Quotient saturated to the distance width; zero divisor reads all ones
    assign quo_ext  = 32'(quo_reg);
    assign dist_new = ((cfg.divisor == 8'd0) || (quo_ext > 32'h0000_FFFF)) ?
                      {DIST_W{1'b1}} : quo_ext[DIST_W-1:0];

    assign tick_plus1 = {1'b0, tick_reg} + 1'b1;

    // Status back to the controller
    always_comb
    begin
        sts.echo            = echo_reg;
        sts.startup_done    = (tick_reg >= cfg.startup_ticks);
        sts.trig_first_done = (cfg.trigger_ticks <= 8'd1);
        sts.trig_done       = (tick_plus1 >= (TICK_W+1)'(cfg.trigger_ticks));
        sts.poll_done       = (tick_plus1 >= {1'b0, cfg.poll_ticks});
        sts.div_done        = !div_busy_reg;
        sts.baseline_taken  = base_reg;
        sts.dist_differs    = (dist_new != dist_reg);
    end

    assign last_distance = dist_reg;

endmodule

FILE: rtl/uer_ctrl.sv
// Controller of the echo-pulse ranger: sequences each tick transaction
// and holds the measurement phase. Depends on uer_pkg.
module uer_ctrl
    import uer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_free,
    input  sts_t sts,
    output cmd_t cmd,
    output logic out_load,
    output logic res_trig,
    output logic res_changed
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   trig_reg, trig_next;
    logic   chg_reg, chg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_STARTUP;
            trig_reg  <= 1'b0;
            chg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            trig_reg  <= trig_next;
            chg_reg   <= chg_next;
        end
    end

    // Next state, phase update and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        trig_next      = trig_reg;
        chg_next       = chg_reg;
        cmd.latch_echo = 1'b0;
        cmd.tick_op    = TICK_HOLD;
        cmd.width_op   = WIDTH_HOLD;
        cmd.div_start  = 1'b0;
        cmd.dist_load  = 1'b0;
        cmd.base_set   = 1'b0;
        out_load       = 1'b0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_echo = 1'b1;
                    state_next     = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                trig_next  = 1'b0;
                chg_next   = 1'b0;
                state_next = ST_FINISH;
                case (phase_reg)
                    PH_STARTUP:
                    begin
                        // startup over: first trigger tick happens this tick
                        if (sts.startup_done)
                        begin
                            trig_next = 1'b1;
                            if (sts.trig_first_done)
                            begin
                                phase_next  = PH_WAIT;
                                cmd.tick_op = TICK_CLEAR;
                            end
                            else
                            begin
                                phase_next  = PH_TRIGGER;
                                cmd.tick_op = TICK_ONE;
                            end
                        end
                        else
                            cmd.tick_op = TICK_INC;
                    end
                    PH_TRIGGER:
                    begin
                        trig_next = 1'b1;
                        if (sts.trig_done)
                        begin
                            phase_next  = PH_WAIT;
                            cmd.tick_op = TICK_CLEAR;
                        end
                        else
                            cmd.tick_op = TICK_INC;
                    end
                    PH_WAIT:
                    begin
                        if (sts.echo)
                        begin
                            cmd.width_op = WIDTH_ONE;
                            phase_next   = PH_MEASURE;
                        end
                    end
                    PH_MEASURE:
                    begin
                        // falling echo: convert width to distance
                        if (sts.echo)
                            cmd.width_op = WIDTH_INC;
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    PH_POLL:
                    begin
                        if (sts.poll_done)
                        begin
                            phase_next  = PH_TRIGGER;
                            cmd.tick_op = TICK_CLEAR;
                        end
                        else
                            cmd.tick_op = TICK_INC;
                    end
                    default:
                    begin
                        phase_next = PH_STARTUP;
                    end
                endcase
            end

            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.tick_op   = TICK_CLEAR;
                    cmd.dist_load = 1'b1;
                    state_next    = ST_FINISH;
                    if (!sts.baseline_taken)
                    begin
                        cmd.base_set = 1'b1;
                        phase_next   = PH_TRIGGER;
                    end
                    else
                    begin
                        chg_next   = sts.dist_differs;
                        phase_next = PH_POLL;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_trig    = trig_reg;
    assign res_changed = chg_reg;

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Echo-pulse range finder. Each input transaction is one microsecond tick
// carrying the sampled echo level; each tick yields exactly one output
// transaction with the trigger level, the stored distance and a change flag.
// A tick passes through the controller states EXEC and FINISH on its way to
// the result register; the tick on which the echo falls also passes through
// DIV, where the restoring divider produces one quotient bit per cycle.
// The result sits in an output register; the next tick is accepted while it
// waits, and that tick's result waits for the register to free up.
// Configuration writes are always accepted and are meant for idle times.
// Top level; depends on uer_pkg, uer_ctrl and uer_dp.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  echo_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  trigger_level,
    output logic [DIST_W-1:0]     distance_cm,
    output logic                  changed,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    cmd_t              cmd;
    sts_t              sts;
    logic              out_free;
    logic              out_load;
    logic              res_trig;
    logic              res_changed;
    logic [DIST_W-1:0] last_distance;

    logic              out_valid_reg;
    logic              trig_out_reg;
    logic              chg_out_reg;
    logic [DIST_W-1:0] dist_out_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= TRIGGER_TICKS_RST;
            cfg_reg.startup_ticks <= STARTUP_TICKS_RST;
            cfg_reg.poll_ticks    <= POLL_TICKS_RST;
            cfg_reg.divisor       <= DIVISOR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= cfg_data[7:0];
                REG_STARTUP_TICKS: cfg_reg.startup_ticks <= cfg_data;
                REG_POLL_TICKS:    cfg_reg.poll_ticks    <= cfg_data;
                REG_DIVISOR:       cfg_reg.divisor       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    uer_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_free    (out_free),
        .sts         (sts),
        .cmd         (cmd),
        .out_load    (out_load),
        .res_trig    (res_trig),
        .res_changed (res_changed)
    );

    uer_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .echo_level    (echo_level),
        .cmd           (cmd),
        .sts           (sts),
        .last_distance (last_distance)
    );

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            trig_out_reg <= res_trig;
            chg_out_reg  <= res_changed;
            dist_out_reg <= last_distance;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = trig_out_reg;
    assign changed       = chg_out_reg;
    assign distance_cm   = dist_out_reg;

endmodule
